// ----- src/waveform_noise_rate_accumulator_defines.svh -----
// Assertion macros shared by the waveform noise rate accumulator sources.
`ifndef WAVEFORM_NOISE_RATE_ACCUMULATOR_DEFINES_SVH
`define WAVEFORM_NOISE_RATE_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTH
// clocked check, off while reset is high
`define WNRA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, also live during reset
`define WNRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WNRA_ASSERT(lbl, clk, rst, prop, msg)
`define WNRA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/wnra_pkg.sv -----
// Shared types and constants of the waveform noise rate accumulator.
package wnra_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int GAIN_W     = 24;
  localparam int NOISE_W    = 24;
  localparam int SEGF_W     = 4;
  localparam int SCALE_W    = 32;
  localparam int RATE_W     = 48;
  localparam int TOTAL_W    = 64;
  localparam int EVT_W      = 32;
  localparam int G2_W       = 48;
  localparam int NOISE2_W   = 48;
  localparam int PROD_W     = 136;  // serial multiplier / divider word
  localparam int MB_W       = 64;   // serial multiplier operand B
  localparam int RATE_LSB   = 48;   // Q32 * Q16.16 -> drop 48 fraction bits
  localparam int RATE_OVF   = 96;   // product at or above 2^96 saturates
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    MS_NS2,    // N * sum of squares
    MS_S1S1,   // sum squared, subtracted from the above
    MS_MAG,    // |gain|^2
    MS_NN,     // N^2
    MS_NOISE,  // noise^2
    MS_VAR,    // numerator * |gain|^2
    MS_RATE    // excess * rate_scale
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     step;
    logic     mul_load;
    logic     mul_run;
    logic     mul_store;
    mul_sel_t mul_sel;
    logic     div_load;
    logic     div_run;
    logic     div_store;
    logic     seg_read;
    logic     seg_write;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_last;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- src/wnra_ctrl.sv -----
// Sequencer of the waveform noise rate accumulator.
`include "waveform_noise_rate_accumulator_defines.svh"
module wnra_ctrl
  import wnra_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_MUL_LOAD, S_MUL_RUN, S_MUL_STORE,
    S_DIV_LOAD, S_DIV_RUN, S_DIV_STORE, S_SEG_RD, S_SEG_WR, S_OUT
  } state_t;

  state_t   state;
  mul_sel_t sel;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= MS_NS2;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_STEP;
        end
        S_STEP: begin
          if (sts.is_clear || !sts.is_last) begin
            state <= S_IDLE;
          end else begin
            sel   <= MS_NS2;
            state <= S_MUL_LOAD;
          end
        end
        S_MUL_LOAD: state <= S_MUL_RUN;
        S_MUL_RUN: begin
          if (sts.mul_done) state <= S_MUL_STORE;
        end
        S_MUL_STORE: begin
          unique case (sel)
            MS_NS2:   begin sel <= MS_S1S1;  state <= S_MUL_LOAD; end
            MS_S1S1:  begin sel <= MS_MAG;   state <= S_MUL_LOAD; end
            MS_MAG:   begin sel <= MS_NN;    state <= S_MUL_LOAD; end
            MS_NN:    begin sel <= MS_NOISE; state <= S_MUL_LOAD; end
            MS_NOISE: begin sel <= MS_VAR;   state <= S_MUL_LOAD; end
            MS_VAR:   state <= S_DIV_LOAD;
            MS_RATE:  state <= S_SEG_RD;
            default:  state <= S_IDLE;
          endcase
        end
        S_DIV_LOAD: state <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (sts.div_done) state <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          sel   <= MS_RATE;
          state <= S_MUL_LOAD;
        end
        S_SEG_RD: state <= S_SEG_WR;
        S_SEG_WR: state <= S_OUT;
        S_OUT: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = sel;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.step      = (state == S_STEP);
    cmd.mul_load  = (state == S_MUL_LOAD);
    cmd.mul_run   = (state == S_MUL_RUN);
    cmd.mul_store = (state == S_MUL_STORE);
    cmd.div_load  = (state == S_DIV_LOAD);
    cmd.div_run   = (state == S_DIV_RUN);
    cmd.div_store = (state == S_DIV_STORE);
    cmd.seg_read  = (state == S_SEG_RD);
    cmd.seg_write = (state == S_SEG_WR);
    cmd.out_load  = (state == S_OUT) && !sts.out_busy;
  end

  `WNRA_ASSERT(a_accept_step, clk, rst, (in_valid && in_ready) |=> (state == S_STEP), "accepted transaction not stepped")
  `WNRA_ASSERT(a_no_accept_busy, clk, rst, (state == S_MUL_RUN) |-> !cmd.capture, "capture while computing")

endmodule

// ----- src/wnra_dp.sv -----
// Datapath: accumulators, serial multiplier, divider, segment store, output register.
`include "waveform_noise_rate_accumulator_defines.svh"
module wnra_dp
  import wnra_pkg::*;
#(
  parameter int MAX_SAMPLES  = 64,
  parameter int NUM_SEGMENTS = 16,
  parameter int SAMPLE_BITS  = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic                     cfg_we,
  input  logic [SCALE_W-1:0]       cfg_wdata,
  input  logic                     in_operation,
  input  logic [SAMPLE_W-1:0]      in_sample,
  input  logic                     in_last,
  input  logic                     in_new_event,
  input  logic signed [GAIN_W-1:0] in_gain,
  input  logic [NOISE_W-1:0]       in_noise,
  input  logic [SEGF_W-1:0]        in_segment,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [RATE_W-1:0]        out_rate,
  output logic [SEGF_W-1:0]        out_segment,
  output logic [TOTAL_W-1:0]       out_total,
  output logic [EVT_W-1:0]         out_events
);

  localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W    = EFF_BITS + CNT_W;
  localparam int SQ_W     = 2 * EFF_BITS + CNT_W;
  localparam int NUM_W    = SQ_W + CNT_W;
  localparam int NN_W     = 2 * CNT_W;
  localparam int SEG_IW   = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int DC_W     = $clog2(PROD_W + 1);

  // captured item
  logic                op_r, last_r, evt_flag_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [NOISE_W-1:0]  noise_r;
  logic [SEGF_W-1:0]   segf_r;

  logic [SCALE_W-1:0]  scale;
  logic [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]     sq_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [EVT_W-1:0]    evt;

  logic [NUM_W-1:0]    num_r;
  logic [G2_W-1:0]     g2_r;
  logic [NN_W-1:0]     nn_r;
  logic [NOISE2_W-1:0] noise2_r;
  logic [PROD_W-1:0]   excess_r;
  logic [RATE_W-1:0]   rate_r;

  logic [PROD_W-1:0]   prod, mcand;
  logic [MB_W-1:0]     mplier;
  logic [PROD_W-1:0]   op_a;
  logic [MB_W-1:0]     op_b;

  logic [PROD_W-1:0]   dvd;
  logic [NN_W-1:0]     rem;
  logic [DC_W-1:0]     dcnt;
  logic [NN_W:0]       dtrial;
  logic                dge;

  logic [TOTAL_W-1:0]  seg_mem [NUM_SEGMENTS];
  logic [NUM_SEGMENTS-1:0] seg_vld;
  logic [TOTAL_W-1:0]  rd_data;
  logic                rd_vld;
  logic [TOTAL_W-1:0]  total_r;

  logic [EFF_BITS-1:0] s_eff;
  logic [2*EFF_BITS-1:0] s_sq;
  logic [GAIN_W-1:0]   mag;
  logic [7:0]          seg_wide, seg_clamp;
  logic [SEG_IW-1:0]   seg_idx;
  logic [TOTAL_W:0]    seg_sum;
  logic [TOTAL_W-1:0]  seg_old, seg_new;

  assign s_eff = sample_r[EFF_BITS-1:0];
  assign s_sq  = s_eff * s_eff;
  assign mag   = gain_r[GAIN_W-1] ? (~gain_r + GAIN_W'(1)) : gain_r;

  // out-of-range segment folds onto the top one
  assign seg_wide  = {{(8 - SEGF_W){1'b0}}, segf_r};
  assign seg_clamp = (seg_wide >= 8'(NUM_SEGMENTS)) ? 8'(NUM_SEGMENTS - 1) : seg_wide;
  assign seg_idx   = seg_clamp[SEG_IW-1:0];

  assign seg_old = rd_vld ? rd_data : '0;
  assign seg_sum = {1'b0, seg_old} + {{(TOTAL_W + 1 - RATE_W){1'b0}}, rate_r};
  assign seg_new = seg_sum[TOTAL_W] ? '1 : seg_sum[TOTAL_W-1:0];

  assign dtrial = {rem, dvd[PROD_W-1]};
  assign dge    = dtrial >= {1'b0, nn_r};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MS_NS2:   begin op_a = PROD_W'(sq_r);     op_b = MB_W'(cnt_r);  end
      MS_S1S1:  begin op_a = PROD_W'(sum_r);    op_b = MB_W'(sum_r);  end
      MS_MAG:   begin op_a = PROD_W'(mag);      op_b = MB_W'(mag);    end
      MS_NN:    begin op_a = PROD_W'(cnt_r);    op_b = MB_W'(cnt_r);  end
      MS_NOISE: begin op_a = PROD_W'(noise_r);  op_b = MB_W'(noise_r); end
      MS_VAR:   begin op_a = PROD_W'(num_r);    op_b = MB_W'(g2_r);   end
      MS_RATE:  begin op_a = excess_r;          op_b = MB_W'(scale);  end
      default:  begin op_a = '0;                op_b = '0;            end
    endcase
  end

  assign sts.is_clear = (op_r == OP_CLEAR);
  assign sts.is_last  = last_r;
  assign sts.mul_done = (mplier == '0);
  assign sts.div_done = (dcnt == '0);
  assign sts.out_busy = out_valid && !out_ready;

  // control-side state: reset clears it and presets rate_scale to 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      scale   <= SCALE_RESET;
      sum_r   <= '0;
      sq_r    <= '0;
      cnt_r   <= '0;
      evt     <= '0;
      seg_vld <= '0;
      dcnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) scale <= cfg_wdata;
      if (cmd.step) begin
        if (op_r == OP_CLEAR) begin
          seg_vld <= '0;
          evt     <= '0;
        end else begin
          if (evt_flag_r && (evt != '1)) evt <= evt + EVT_W'(1);
          if (cnt_r < CNT_W'(MAX_SAMPLES)) begin
            sum_r <= sum_r + SUM_W'(s_eff);
            sq_r  <= sq_r + SQ_W'(s_sq);
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
      end
      if (cmd.seg_write) begin
        seg_vld[seg_idx] <= 1'b1;
        sum_r <= '0;
        sq_r  <= '0;
        cnt_r <= '0;
      end
      if (cmd.div_load) dcnt <= DC_W'(PROD_W);
      else if (cmd.div_run && (dcnt != '0)) dcnt <= dcnt - DC_W'(1);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      last_r     <= in_last;
      evt_flag_r <= in_new_event;
      sample_r   <= in_sample;
      gain_r     <= in_gain;
      noise_r    <= in_noise;
      segf_r     <= in_segment;
    end
    if (cmd.mul_load) begin
      prod   <= '0;
      mcand  <= op_a;
      mplier <= op_b;
    end else if (cmd.mul_run && (mplier != '0)) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
    if (cmd.mul_store) begin
      case (cmd.mul_sel)
        MS_NS2:   num_r <= NUM_W'(prod);
        MS_S1S1:  num_r <= (PROD_W'(num_r) > prod) ? NUM_W'(PROD_W'(num_r) - prod) : '0;
        MS_MAG:   g2_r <= G2_W'(prod);
        MS_NN:    nn_r <= NN_W'(prod);
        MS_NOISE: noise2_r <= NOISE2_W'(prod);
        MS_RATE:  rate_r <= (|prod[PROD_W-1:RATE_OVF]) ? '1 : prod[RATE_OVF-1:RATE_LSB];
        default:  ;
      endcase
    end
    // restoring divide, one quotient bit a cycle; quotient shifts into dvd
    if (cmd.div_load) begin
      dvd <= prod;
      rem <= '0;
    end else if (cmd.div_run && (dcnt != '0)) begin
      rem <= dge ? NN_W'(dtrial - {1'b0, nn_r}) : dtrial[NN_W-1:0];
      dvd <= {dvd[PROD_W-2:0], dge};
    end
    if (cmd.div_store) begin
      excess_r <= (dvd > PROD_W'(noise2_r)) ? (dvd - PROD_W'(noise2_r)) : '0;
    end
    if (cmd.seg_read) begin
      rd_data <= seg_mem[seg_idx];
      rd_vld  <= seg_vld[seg_idx];
    end
    if (cmd.seg_write) begin
      seg_mem[seg_idx] <= seg_new;
      total_r <= seg_new;
    end
    if (cmd.out_load) begin
      out_rate    <= rate_r;
      out_segment <= seg_clamp[SEGF_W-1:0];
      out_total   <= total_r;
      out_events  <= evt;
    end
  end

  `WNRA_ASSERT(a_out_load_valid, clk, rst, cmd.out_load |=> out_valid, "result register not loaded")
  `WNRA_ASSERT_ALWAYS(a_write_after_read, clk, cmd.seg_write |-> $past(cmd.seg_read), "segment write without read")
  `WNRA_ASSERT(a_div_after_mul, clk, rst, cmd.div_load |-> $past(cmd.mul_store), "divide started out of sequence")
  `WNRA_ASSERT(a_cnt_bound, clk, rst, cmd.step |=> (cnt_r <= CNT_W'(MAX_SAMPLES)), "sample count past limit")

endmodule

// ----- src/waveform_noise_rate_accumulator.sv -----
// Top level of the waveform noise rate accumulator.
//
// Input stream (s_*): one transaction per ADC sample or command. s_tuser is the
// operation (0 sample, 1 clear segment sums and event count); s_tlast marks the
// final sample of a crystal waveform. Only the last sample of a waveform gives
// a result on the output stream (m_*); samples and clears give none.
// A non-last sample or a clear is accepted and then applied in an update step,
// after which s_tready rises again. A last sample runs the finishing sequence
// on one shared shift-add multiplier (7 products, one multiplier bit a cycle)
// and one restoring divider (136 quotient bits, one quotient bit a cycle).
// Results wait in an output register; new transactions are taken while one
// waits, and the sequence stalls only at its final step if m_tready is low.
// Reset (rst, synchronous) zeroes the running sums, event count and segment
// valid bits, and sets rate_scale to 1.0 (Q16.16). cfg_we writes rate_scale.
module waveform_noise_rate_accumulator
  import wnra_pkg::*;
#(
  parameter int MAX_SAMPLES  = 64,
  parameter int NUM_SEGMENTS = 16,
  parameter int SAMPLE_BITS  = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SCALE_W-1:0]  cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  // sample[17:0], new_event[18], gain[42:19], noise_energy[66:43], segment[70:67]
  input  logic [71:0]         s_tdata,
  // operation[0]
  input  logic                s_tuser,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  // crystal_rate[47:0], segment_out[51:48], segment_total[115:52], events_seen[147:116]
  output logic [151:0]        m_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [RATE_W-1:0]  rate;
  logic [SEGF_W-1:0]  seg_out;
  logic [TOTAL_W-1:0] total;
  logic [EVT_W-1:0]   events;

  wnra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wnra_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_operation (s_tuser),
    .in_sample    (s_tdata[17:0]),
    .in_last      (s_tlast),
    .in_new_event (s_tdata[18]),
    .in_gain      (s_tdata[42:19]),
    .in_noise     (s_tdata[66:43]),
    .in_segment   (s_tdata[70:67]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_rate     (rate),
    .out_segment  (seg_out),
    .out_total    (total),
    .out_events   (events)
  );

  // pack the result, zero fill to whole bytes
  assign m_tdata = {4'b0, events, total, seg_out, rate};

endmodule
